[rtl/rdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, sizes and helpers for the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int VALUE_BITS = 31;
  localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int BIT_IW     = $clog2(VALUE_BITS);
  localparam int DEC_IW     = $clog2(DEC_DIGITS);
  localparam int HEX_IW     = $clog2(HEX_DIGITS);

  localparam int BASE_W      = 2;
  localparam int HEX_SEL_BIT = 1;
  localparam int DEC_SEL_BIT = 0;

  localparam int CHAR_W = 7;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
  localparam logic [CHAR_W-1:0] TEN        = 7'd10;
  localparam logic [3:0]        DIGIT_MAX  = 4'd9;
  localparam logic [3:0]        BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0]        BCD_ADJ     = 4'd3;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [BASE_W-1:0]     base_select;
  } src_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } dst_word_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic size;
    logic emit;
  } rdc_cmd_t;

  typedef struct packed {
    logic idx_zero;
    logic out_free;
  } rdc_sts_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {3'b000, d};
    if (d > DIGIT_MAX) begin
      digit_ascii = ASCII_A + dx - TEN;
    end else begin
      digit_ascii = ASCII_ZERO + dx;
    end
  endfunction

endpackage

[rtl/rdc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_datapath
// Double-dabble shifter, digit count, digit select and output register.
// ----------------------------------------------------------------------------
module rdc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  rdc_pkg::src_word_t src_word,
  input  rdc_pkg::rdc_cmd_t  cmd,
  output rdc_pkg::rdc_sts_t  sts,
  output logic              dst_valid,
  input  logic              dst_stall,
  output rdc_pkg::dst_word_t dst_word
);
  import rdc_pkg::*;

  logic [VALUE_BITS-1:0]            val_q;
  logic [BASE_W-1:0]                base_q;
  logic [VALUE_BITS-1:0]            shreg;
  logic [DEC_DIGITS-1:0][3:0]       bcd;
  logic [DEC_DIGITS-1:0][3:0]       adj;
  logic [4*DEC_DIGITS-1:0]          adj_flat;
  logic [CNT_W-1:0]                 sig_bits;
  logic [BIT_IW-1:0]                idx;
  logic [BIT_IW-1:0]                idx_next;
  logic [HEX_DIGITS-1:0][3:0]       hex_nib;
  logic [CNT_W:0]                   hex_bits;
  logic [CNT_W-1:0]                 hex_cnt;
  logic [DEC_IW:0]                  dec_cnt;
  logic [CNT_W-1:0]                 n_digits;
  logic [3:0]                       digit;

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[i] = (bcd[i] >= BCD_ADJ_MIN) ? bcd[i] + BCD_ADJ : bcd[i];
    end
  end
  assign adj_flat = adj;

  assign hex_nib  = (4 * HEX_DIGITS)'(val_q);
  assign hex_bits = {1'b0, sig_bits} + (CNT_W + 1)'(3);
  assign hex_cnt  = CNT_W'(hex_bits >> 2);

  always_comb begin
    dec_cnt = (DEC_IW + 1)'(1);
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        dec_cnt = (DEC_IW + 1)'(i + 1);
      end
    end
  end

  always_comb begin
    priority if (base_q[HEX_SEL_BIT]) begin
      n_digits = hex_cnt;
    end else if (base_q[DEC_SEL_BIT]) begin
      n_digits = CNT_W'(dec_cnt);
    end else begin
      n_digits = sig_bits;
    end
    if (n_digits == '0) begin
      n_digits = CNT_W'(1);
    end
    idx_next = BIT_IW'(n_digits - CNT_W'(1));
  end

  always_comb begin
    priority if (base_q[HEX_SEL_BIT]) begin
      digit = hex_nib[idx[HEX_IW-1:0]];
    end else if (base_q[DEC_SEL_BIT]) begin
      digit = bcd[idx[DEC_IW-1:0]];
    end else begin
      digit = {3'b000, val_q[idx]};
    end
  end

  assign sts.idx_zero = (idx == '0);
  assign sts.out_free = !dst_valid || !dst_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_q    <= src_word.value;
      base_q   <= src_word.base_select;
      shreg    <= src_word.value;
      bcd      <= '0;
      sig_bits <= '0;
    end
    if (cmd.shift) begin
      shreg <= {shreg[VALUE_BITS-2:0], 1'b0};
      bcd   <= {adj_flat[4*DEC_DIGITS-2:0], shreg[VALUE_BITS-1]};
      if (sig_bits != '0 || shreg[VALUE_BITS-1]) begin
        sig_bits <= sig_bits + CNT_W'(1);
      end
    end
    if (cmd.size) begin
      idx <= idx_next;
    end
    if (cmd.emit) begin
      dst_word.digit_char <= digit_ascii(digit);
      dst_word.last_digit <= (idx == '0);
      idx                 <= idx - BIT_IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (cmd.emit) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

endmodule

[rtl/rdc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer: accept, shift, size the digit string, emit digits.
// ----------------------------------------------------------------------------
module rdc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  rdc_pkg::rdc_sts_t  sts,
  output rdc_pkg::rdc_cmd_t  cmd
);
  import rdc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONVERT,
    S_SIZE,
    S_EMIT
  } state_t;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_BITS - 1);

  state_t           state;
  logic [CNT_W-1:0] cnt;

  assign src_stall = (state != S_IDLE);
  assign cmd.load  = (state == S_IDLE) && src_valid;
  assign cmd.shift = (state == S_CONVERT);
  assign cmd.size  = (state == S_SIZE);
  assign cmd.emit  = (state == S_EMIT) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (src_valid) begin
            state <= S_CONVERT;
          end
        end
        S_CONVERT: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == LAST_STEP) begin
            state <= S_SIZE;
          end
        end
        S_SIZE: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (sts.out_free && sts.idx_zero) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("digit emitted into a full output register");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.idx_zero) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after the last digit");

  a_accept_convert: assert property (@(posedge clk) disable iff (rst)
    (src_valid && !src_stall) |=> (state == S_CONVERT) && (cnt == '0))
    else $error("accepted word did not start a conversion");

  a_convert_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONVERT && cnt == LAST_STEP) |=> (state == S_SIZE))
    else $error("conversion did not end after the full shift count");

endmodule

[rtl/radix_digit_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts one integer into ASCII digits of base 2, 10 or 16, most
// significant digit first, with the last digit marked.
// ----------------------------------------------------------------------------
//  channel  | handshake              | word
//  src      | src_valid / src_stall  | src_word  (value, base_select)
//  dst      | dst_valid / dst_stall  | dst_word  (digit_char, last_digit)
//
//  A word is shifted one bit per cycle by the double-dabble shift, then
//  the digit string is sized and its digits are emitted.
//  Reset is synchronous and clears only the sequencer and dst_valid.
//  dst_stall holds emission; src_stall is high from accept until the last
//  digit enters the output register.
// ----------------------------------------------------------------------------
module radix_digit_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  rdc_pkg::src_word_t src_word,
  output logic              dst_valid,
  input  logic              dst_stall,
  output rdc_pkg::dst_word_t dst_word
);
  import rdc_pkg::*;

  rdc_cmd_t cmd;
  rdc_sts_t sts;

  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .src_word  (src_word),
    .cmd       (cmd),
    .sts       (sts),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
  );

endmodule
